>>> rtl/sss_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and control structures for the sample set statistics block.
package sss_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CNT_BITS    = 17;
  localparam int SUM_BITS    = 33;
  localparam int SQS_BITS    = 47;
  localparam int SQS_LO_BITS = 24;
  localparam int WIDE_BITS   = 64;
  localparam int DIV_BITS    = 63;
  localparam int DEN_BITS    = 32;
  localparam int ROOT_BITS   = 32;
  localparam int OUT_BITS    = 16;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

  localparam logic [CNT_BITS-1:0] MAX_SAMPLES = CNT_BITS'(65536);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SQ,
    ST_VAR_GO,
    ST_VAR_WAIT,
    ST_ROOT_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic mean_load;
    logic mean_store;
    logic mul_lo;
    logic mul_hi;
    logic mul_sq;
    logic var_load;
    logic root_load;
    logic dev_store;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_lt2;
    logic div_idle;
    logic root_idle;
  } status_t;

endpackage

>>> rtl/sss_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module sss_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic [sss_pkg::DIV_BITS-1:0]      dividend,
  input  logic [sss_pkg::DEN_BITS-1:0]      divisor,
  output logic                              idle,
  output logic [sss_pkg::DIV_BITS-1:0]      quotient
);

  logic                                active;
  logic [sss_pkg::DIV_CNT_BITS-1:0]    steps;
  logic [sss_pkg::DEN_BITS-1:0]        rem;
  logic [sss_pkg::DEN_BITS-1:0]        den;
  logic [sss_pkg::DIV_BITS-1:0]        quo;
  logic [sss_pkg::DEN_BITS:0]          rem_shift;
  logic [sss_pkg::DEN_BITS:0]          rem_diff;
  logic                                fits;

  assign rem_shift = {rem, quo[sss_pkg::DIV_BITS-1]};
  assign rem_diff  = rem_shift - {1'b0, den};
  assign fits      = rem_shift >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      steps  <= '0;
    end else if (load) begin
      active <= 1'b1;
      steps  <= sss_pkg::DIV_CNT_BITS'(sss_pkg::DIV_BITS - 1);
    end else if (active) begin
      steps <= steps - 1'b1;
      if (steps == '0) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      den <= divisor;
      quo <= dividend;
    end else if (active) begin
      rem <= fits ? rem_diff[sss_pkg::DEN_BITS-1:0] : rem_shift[sss_pkg::DEN_BITS-1:0];
      quo <= {quo[sss_pkg::DIV_BITS-2:0], fits};
    end
  end

  assign idle     = !active;
  assign quotient = quo;

endmodule

>>> rtl/sss_sqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit integer square root, two radicand bits per cycle.
module sss_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic [sss_pkg::DIV_BITS-1:0]   radicand,
  output logic                           idle,
  output logic [sss_pkg::ROOT_BITS-1:0]  root
);

  logic                              active;
  logic [sss_pkg::DIV_BITS-1:0]      x;
  logic [sss_pkg::DIV_BITS-1:0]      acc;
  logic [sss_pkg::DIV_BITS-1:0]      probe;
  logic [sss_pkg::DIV_BITS:0]        trial;
  logic                              fits;

  assign trial = {1'b0, acc} + {1'b0, probe};
  assign fits  = {1'b0, x} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (active && probe[0]) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x     <= radicand;
      acc   <= '0;
      probe <= {1'b1, {(sss_pkg::DIV_BITS-1){1'b0}}};
    end else if (active) begin
      if (fits) begin
        x   <= x - trial[sss_pkg::DIV_BITS-1:0];
        acc <= (acc >> 1) + probe;
      end else begin
        acc <= acc >> 1;
      end
      probe <= probe >> 2;
    end
  end

  assign idle = !active;
  assign root = acc[sss_pkg::ROOT_BITS-1:0];

endmodule

>>> rtl/sss_datapath.sv
`timescale 1ns / 1ps
// Accumulators, multipliers and result registers of the sample set statistics block.
module sss_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sss_pkg::cmd_t                         cmd,
  output sss_pkg::status_t                      status,
  input  logic signed [sss_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                  has_sample,
  output logic [sss_pkg::CNT_BITS-1:0]          count,
  output logic signed [sss_pkg::OUT_BITS-1:0]   minimum,
  output logic signed [sss_pkg::OUT_BITS-1:0]   maximum,
  output logic signed [sss_pkg::OUT_BITS-1:0]   mean,
  output logic [sss_pkg::OUT_BITS-1:0]          deviation,
  output logic                                  overflowed
);

  logic [sss_pkg::CNT_BITS-1:0]          cnt;
  logic signed [sss_pkg::SUM_BITS-1:0]   sum;
  logic [sss_pkg::SQS_BITS-1:0]          sq_sum;
  logic signed [sss_pkg::OUT_BITS-1:0]   mn;
  logic signed [sss_pkg::OUT_BITS-1:0]   mx;
  logic                                  drop;
  logic signed [sss_pkg::OUT_BITS-1:0]   mean_reg;
  logic [sss_pkg::OUT_BITS-1:0]          dev_reg;
  logic [sss_pkg::DEN_BITS-1:0]          mag;
  logic [sss_pkg::WIDE_BITS-1:0]         num;
  logic [sss_pkg::WIDE_BITS-1:0]         sq;
  logic [sss_pkg::DEN_BITS-1:0]          den;

  logic signed [sss_pkg::OUT_BITS-1:0]   s;
  logic signed [2*sss_pkg::OUT_BITS-1:0] s_sq;
  logic [sss_pkg::SUM_BITS-1:0]          mag_full;
  logic [sss_pkg::WIDE_BITS-1:0]         diff;
  logic [sss_pkg::CNT_BITS+sss_pkg::SQS_LO_BITS-1:0] prod_lo;
  logic [sss_pkg::CNT_BITS+sss_pkg::SQS_BITS-sss_pkg::SQS_LO_BITS-1:0] prod_hi;
  logic [2*sss_pkg::CNT_BITS-1:0]        prod_den;
  logic [2*sss_pkg::DEN_BITS-1:0]        prod_sq;
  logic                                  div_load;
  logic [sss_pkg::DIV_BITS-1:0]          div_dividend;
  logic [sss_pkg::DEN_BITS-1:0]          div_divisor;
  logic                                  div_idle;
  logic [sss_pkg::DIV_BITS-1:0]          quotient;
  logic                                  root_idle;
  logic [sss_pkg::ROOT_BITS-1:0]         root;
  logic [sss_pkg::OUT_BITS-1:0]          q_low;

  assign s    = sss_pkg::OUT_BITS'($signed(sample[sss_pkg::SAMPLE_BITS-1:0]));
  assign s_sq = s * s;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt      <= '0;
      sum      <= '0;
      sq_sum   <= '0;
      mn       <= '0;
      mx       <= '0;
      drop     <= 1'b0;
      mean_reg <= '0;
      dev_reg  <= '0;
    end else begin
      if (cmd.accept && has_sample) begin
        if (cnt >= sss_pkg::MAX_SAMPLES) begin
          drop <= 1'b1;
        end else begin
          if (cnt == '0 || s < mn) begin
            mn <= s;
          end
          if (cnt == '0 || s > mx) begin
            mx <= s;
          end
          sum    <= sum + sss_pkg::SUM_BITS'(s);
          sq_sum <= sq_sum + sss_pkg::SQS_BITS'($unsigned(s_sq));
          cnt    <= cnt + 1'b1;
        end
      end
      if (cmd.mean_store) begin
        mean_reg <= sum[sss_pkg::SUM_BITS-1] ? -q_low : q_low;
      end
      if (cmd.dev_store) begin
        dev_reg <= (root[sss_pkg::ROOT_BITS-1:sss_pkg::OUT_BITS] != '0) ? '1
                                                                        : root[sss_pkg::OUT_BITS-1:0];
      end
    end
  end

  assign mag_full = sum[sss_pkg::SUM_BITS-1] ? $unsigned(-sum) : $unsigned(sum);
  assign q_low    = quotient[sss_pkg::OUT_BITS-1:0];

  assign prod_lo  = $bits(prod_lo)'(cnt) * $bits(prod_lo)'(sq_sum[sss_pkg::SQS_LO_BITS-1:0]);
  assign prod_hi  = $bits(prod_hi)'(cnt)
                  * $bits(prod_hi)'(sq_sum[sss_pkg::SQS_BITS-1:sss_pkg::SQS_LO_BITS]);
  assign prod_den = $bits(prod_den)'(cnt) * $bits(prod_den)'(cnt - 1'b1);
  assign prod_sq  = $bits(prod_sq)'(mag) * $bits(prod_sq)'(mag);

  always_ff @(posedge clk) begin
    if (cmd.mean_load) begin
      mag <= mag_full[sss_pkg::DEN_BITS-1:0];
    end
    if (cmd.mul_lo) begin
      num <= sss_pkg::WIDE_BITS'(prod_lo);
    end
    if (cmd.mul_hi) begin
      num <= num + (sss_pkg::WIDE_BITS'(prod_hi) << sss_pkg::SQS_LO_BITS);
    end
    if (cmd.mul_sq) begin
      sq  <= prod_sq;
      den <= prod_den[sss_pkg::DEN_BITS-1:0];
    end
  end

  assign diff = (num >= sq) ? num - sq : '0;

  assign div_load     = cmd.mean_load || cmd.var_load;
  assign div_dividend = cmd.mean_load ? sss_pkg::DIV_BITS'(mag_full[sss_pkg::DEN_BITS-1:0])
                                      : diff[sss_pkg::DIV_BITS-1:0];
  assign div_divisor  = cmd.mean_load ? sss_pkg::DEN_BITS'(cnt) : den;

  sss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (div_load),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .idle     (div_idle),
    .quotient (quotient)
  );

  sss_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.root_load),
    .radicand (quotient),
    .idle     (root_idle),
    .root     (root)
  );

  assign status.n_zero    = (cnt == '0);
  assign status.n_lt2     = (cnt < sss_pkg::CNT_BITS'(2));
  assign status.div_idle  = div_idle;
  assign status.root_idle = root_idle;

  assign count      = cnt;
  assign minimum    = mn;
  assign maximum    = mx;
  assign mean       = mean_reg;
  assign deviation  = dev_reg;
  assign overflowed = drop;

endmodule

>>> rtl/sss_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing accumulation, division and root extraction.
module sss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last,
  input  sss_pkg::status_t  status,
  output sss_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              done
);

  sss_pkg::state_t state;
  sss_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      sss_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
        if (start && last) begin
          state_next = sss_pkg::ST_MEAN_GO;
        end
      end
      sss_pkg::ST_MEAN_GO: begin
        if (status.n_zero) begin
          state_next = sss_pkg::ST_EMIT;
        end else begin
          cmd.mean_load = 1'b1;
          state_next    = sss_pkg::ST_MEAN_WAIT;
        end
      end
      sss_pkg::ST_MEAN_WAIT: begin
        if (status.div_idle) begin
          cmd.mean_store = 1'b1;
          state_next     = status.n_lt2 ? sss_pkg::ST_EMIT : sss_pkg::ST_MUL_LO;
        end
      end
      sss_pkg::ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = sss_pkg::ST_MUL_HI;
      end
      sss_pkg::ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = sss_pkg::ST_MUL_SQ;
      end
      sss_pkg::ST_MUL_SQ: begin
        cmd.mul_sq = 1'b1;
        state_next = sss_pkg::ST_VAR_GO;
      end
      sss_pkg::ST_VAR_GO: begin
        cmd.var_load = 1'b1;
        state_next   = sss_pkg::ST_VAR_WAIT;
      end
      sss_pkg::ST_VAR_WAIT: begin
        if (status.div_idle) begin
          cmd.root_load = 1'b1;
          state_next    = sss_pkg::ST_ROOT_WAIT;
        end
      end
      sss_pkg::ST_ROOT_WAIT: begin
        if (status.root_idle) begin
          cmd.dev_store = 1'b1;
          state_next    = sss_pkg::ST_EMIT;
        end
      end
      sss_pkg::ST_EMIT: begin
        done       = 1'b1;
        cmd.clear  = 1'b1;
        state_next = sss_pkg::ST_IDLE;
      end
      default: begin
        state_next = sss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/sample_set_statistics_top.sv
`timescale 1ns / 1ps
// Top level of the sample set statistics block: controller plus datapath.
//
//   channel   handshake          payload
//   input     start, busy        sample, has_sample, last
//   result    done (strobe)      count, minimum, maximum, mean, deviation, overflowed
//
// A transfer that is not marked last leaves busy low, and samples stream in back to back.
// After the last transfer busy stays high while the shared restoring divider and the root
// unit run; for one sample only the mean division runs, and for an empty set neither runs.
// Synchronous reset clears all accumulators and returns the controller to idle.
// The receiver cannot stall: done is high for exactly one cycle and the set then clears.
module sample_set_statistics_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [sss_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   has_sample,
  input  logic                                   last,
  output logic                                   done,
  output logic [sss_pkg::CNT_BITS-1:0]           count,
  output logic signed [sss_pkg::OUT_BITS-1:0]    minimum,
  output logic signed [sss_pkg::OUT_BITS-1:0]    maximum,
  output logic signed [sss_pkg::OUT_BITS-1:0]    mean,
  output logic [sss_pkg::OUT_BITS-1:0]           deviation,
  output logic                                   overflowed
);

  sss_pkg::cmd_t    cmd;
  sss_pkg::status_t status;

  sss_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .last   (last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  sss_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sample     (sample),
    .has_sample (has_sample),
    .count      (count),
    .minimum    (minimum),
    .maximum    (maximum),
    .mean       (mean),
    .deviation  (deviation),
    .overflowed (overflowed)
  );

endmodule

>>> rtl/sss_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the sample set statistics block and their bind.
module sss_checker (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic signed [sss_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   has_sample,
  input  logic                                   last,
  input  logic                                   done,
  input  logic [sss_pkg::CNT_BITS-1:0]           count,
  input  logic signed [sss_pkg::OUT_BITS-1:0]    minimum,
  input  logic signed [sss_pkg::OUT_BITS-1:0]    maximum,
  input  logic signed [sss_pkg::OUT_BITS-1:0]    mean,
  input  logic [sss_pkg::OUT_BITS-1:0]           deviation,
  input  logic                                   overflowed
);

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe outside busy window");

  a_last_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> (busy && !done))
    else $error("closing transfer did not start the final computation");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

  a_small_set_dev: assert property (@(posedge clk) disable iff (rst)
    (done && (count == sss_pkg::CNT_BITS'(0) || count == sss_pkg::CNT_BITS'(1)))
      |-> (deviation == '0))
    else $error("nonzero deviation for fewer than two samples");

  a_empty_set: assert property (@(posedge clk) disable iff (rst)
    (done && count == sss_pkg::CNT_BITS'(0))
      |-> (mean == '0 && minimum == '0 && maximum == '0 && !overflowed))
    else $error("empty set result not all zero");

endmodule

bind sample_set_statistics_top sss_checker u_sss_checker (.*);
